### hdl/kwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, command codes and the control store of the k-way merge
// sequencer.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int UPC_BITS = 2;

	typedef logic [UPC_BITS-1:0] upc_t;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// program steps
	localparam upc_t STEP_WAIT   = 2'd0;
	localparam upc_t STEP_SCAN   = 2'd1;
	localparam upc_t STEP_REPORT = 2'd2;

	// jump conditions
	typedef enum logic [1:0] {
		COND_STEP_CMD,
		COND_SCAN_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  compare;
		logic  report;
		cond_t cond;
		upc_t  jump_pc;
		upc_t  next_pc;
	} ctl_word_t;

	// control store: jump_pc when the condition holds, next_pc otherwise
	function automatic ctl_word_t ucode(input upc_t pc);
		ctl_word_t w;
		case (pc)
			STEP_WAIT: begin
				w = '{accept: 1'b1, compare: 1'b0, report: 1'b0, cond: COND_STEP_CMD,
					jump_pc: STEP_SCAN, next_pc: STEP_WAIT};
			end
			STEP_SCAN: begin
				w = '{accept: 1'b0, compare: 1'b1, report: 1'b0, cond: COND_SCAN_MORE,
					jump_pc: STEP_SCAN, next_pc: STEP_REPORT};
			end
			STEP_REPORT: begin
				w = '{accept: 1'b0, compare: 1'b0, report: 1'b1, cond: COND_OUT_BUSY,
					jump_pc: STEP_REPORT, next_pc: STEP_WAIT};
			end
			default: begin
				w = '{accept: 1'b0, compare: 1'b0, report: 1'b0, cond: COND_STEP_CMD,
					jump_pc: STEP_WAIT, next_pc: STEP_WAIT};
			end
		endcase
		return w;
	endfunction

endpackage

### hdl/k_way_merge_dedup_newest_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_dedup_newest_core
// Merge of several sorted runs with duplicate removal, newest record wins.
// ----------------------------------------------------------------------------
// A load transfer writes one lane head. A step transfer walks the lane heads
// with a single key/stamp comparator fed by one RAM read port, one lane per
// cycle, then loads the result register in the report step; the next input
// is taken once that report step is done. The result register holds the
// finished result while further loads are taken; a following step waits in
// its report cycle only while the previous result is still stalled.
module k_way_merge_dedup_newest_core #(
	parameter int LANES      = 8,
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [2:0]  lane,
	input  logic [63:0] key,
	input  logic [63:0] stamp,
	input  logic        present,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  win_lane,
	output logic [63:0] win_key,
	output logic [63:0] win_stamp,
	output logic [7:0]  dup_mask,
	output logic        ended
);

	localparam int CW = $clog2(LANES);
	localparam int HW = (LANES > 8) ? LANES : 8;
	localparam int RW = KEY_BITS + STAMP_BITS;

	kwm_pkg::upc_t      upc_q;
	kwm_pkg::ctl_word_t ctl;
	logic               cond_hit;

	logic               in_xfer;
	logic               step_xfer;
	logic               lane_ok;
	logic               load_wr;
	logic [CW-1:0]      wr_addr;
	logic [CW-1:0]      rd_addr;
	logic [RW-1:0]      rd_data;
	logic [KEY_BITS-1:0]   rd_key;
	logic [STAMP_BITS-1:0] rd_stamp;

	logic [LANES-1:0]   head_valid_q;
	logic [CW-1:0]      cmp_idx_q;
	logic               found_q;
	logic [CW-1:0]      best_lane_q;
	logic [KEY_BITS-1:0]   best_key_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic [LANES-1:0]   hits_q;
	logic [HW-1:0]      hits_ext;
	logic [LANES-1:0]   lane_bit;

	logic               cur_valid;
	logic               take_new;
	logic               key_eq;
	logic               stamp_gt;

	logic               out_valid_q;
	logic               out_busy;
	logic               out_load;
	logic [2:0]         win_lane_q;
	logic [63:0]        win_key_q;
	logic [63:0]        win_stamp_q;
	logic [7:0]         dup_mask_q;
	logic               ended_q;

	// sequencer
	assign ctl = kwm_pkg::ucode(upc_q);

	assign in_stall  = !ctl.accept;
	assign in_xfer   = in_valid && ctl.accept;
	assign step_xfer = in_xfer && (cmd == kwm_pkg::CMD_STEP);
	assign out_busy  = out_valid_q && out_stall;
	assign out_load  = ctl.report && !out_busy;

	always_comb begin
		case (ctl.cond)
			kwm_pkg::COND_STEP_CMD:  cond_hit = step_xfer;
			kwm_pkg::COND_SCAN_MORE: cond_hit = (cmp_idx_q != CW'(LANES - 1));
			kwm_pkg::COND_OUT_BUSY:  cond_hit = out_busy;
			default:                 cond_hit = 1'b0;
		endcase
	end

	// head store
	assign lane_ok = ({2'b00, lane} < 5'(LANES));
	assign load_wr = in_xfer && (cmd == kwm_pkg::CMD_LOAD) && lane_ok;
	assign wr_addr = CW'(lane);
	// lane 0 is fetched while waiting so the scan starts right after the step
	assign rd_addr = ctl.compare ? CW'(cmp_idx_q + 1'b1) : '0;

	kwm_ram #(
		.WIDTH(RW),
		.DEPTH(LANES)
	) u_head_ram (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (wr_addr),
		.wr_data ({key[KEY_BITS-1:0], stamp[STAMP_BITS-1:0]}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_key   = rd_data[RW-1:STAMP_BITS];
	assign rd_stamp = rd_data[STAMP_BITS-1:0];

	// comparator
	assign cur_valid = head_valid_q[cmp_idx_q];
	assign take_new  = !found_q || (rd_key < best_key_q);
	assign key_eq    = (rd_key == best_key_q);
	assign stamp_gt  = (rd_stamp > best_stamp_q);
	assign lane_bit  = {{(LANES-1){1'b0}}, 1'b1} << cmp_idx_q;
	assign hits_ext  = HW'(hits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= kwm_pkg::STEP_WAIT;
			head_valid_q <= '0;
			cmp_idx_q    <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			upc_q <= cond_hit ? ctl.jump_pc : ctl.next_pc;
			if (load_wr) begin
				head_valid_q[wr_addr] <= present;
			end
			if (step_xfer) begin
				cmp_idx_q <= '0;
				found_q   <= 1'b0;
			end
			if (ctl.compare) begin
				cmp_idx_q <= CW'(cmp_idx_q + 1'b1);
				if (cur_valid && take_new) begin
					found_q <= 1'b1;
				end
			end
			// every lane holding the winning key is consumed
			if (out_load) begin
				head_valid_q <= head_valid_q & ~hits_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_xfer) begin
			hits_q <= '0;
		end
		if (ctl.compare && cur_valid) begin
			if (take_new) begin
				best_lane_q  <= cmp_idx_q;
				best_key_q   <= rd_key;
				best_stamp_q <= rd_stamp;
				hits_q       <= lane_bit;
			end else if (key_eq) begin
				hits_q <= hits_q | lane_bit;
				// stamp tie keeps the lower lane
				if (stamp_gt) begin
					best_lane_q  <= cmp_idx_q;
					best_stamp_q <= rd_stamp;
				end
			end
		end
		if (out_load) begin
			win_lane_q  <= found_q ? 3'(best_lane_q) : '0;
			win_key_q   <= found_q ? 64'(best_key_q) : '0;
			win_stamp_q <= found_q ? 64'(best_stamp_q) : '0;
			dup_mask_q  <= hits_ext[7:0];
			ended_q     <= !found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign win_lane  = win_lane_q;
	assign win_key   = win_key_q;
	assign win_stamp = win_stamp_q;
	assign dup_mask  = dup_mask_q;
	assign ended     = ended_q;

	// the winning lane is always among the consumed lanes
	a_win_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ended |-> dup_mask[win_lane])
		else $error("winning lane missing from dup_mask");

	// an ended result consumes nothing
	a_ended_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ended |-> (dup_mask == 8'd0) && (win_lane == 3'd0))
		else $error("ended result carries a lane");

	// a stalled result is never overwritten by the report step
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("result register reloaded while stalled");

	// the scan visits lanes in order, one per cycle, until the report step
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == kwm_pkg::STEP_SCAN |=>
			(upc_q == kwm_pkg::STEP_REPORT) ||
			(cmp_idx_q == CW'($past(cmp_idx_q) + 1'b1)))
		else $error("scan counter skipped a lane");

endmodule

### hdl/kwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
